// ----- src/mnp_pkg.sv -----
// Shared types, constants and pitch tables for the note parser.
// Used by mnp_ctrl, mnp_datapath and music_notation_note_parser.
// No dependencies.
package mnp_pkg;

    localparam int FREQ_FRAC_BITS = 8;

    localparam int SYM_W     = 8;
    localparam int KIND_W    = 2;
    localparam int FREQ_W    = 24;
    localparam int DUR_W     = 20;
    localparam int UNIT_W    = 16;
    localparam int OCTAVE_W  = 4;
    localparam int LEN_W     = 4;
    localparam int LETTER_W  = 3;
    localparam int PITCH_W   = 26;
    localparam int EXP_W     = 7;
    localparam int REM_W     = LEN_W;

    // Shift limits of the frequency scaling.
    localparam int LSH_MAX    = FREQ_W;
    localparam int RSH_MAX    = 40;
    localparam int LSH_W      = PITCH_W + LSH_MAX;
    localparam int RND_W      = RSH_MAX + 2;
    localparam int LSH_AMT_W  = $clog2(LSH_MAX + 1);
    localparam int RSH_AMT_W  = $clog2(RSH_MAX + 1);

    // One quotient bit per division step.
    localparam int DIV_STEPS = DUR_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // APB register map.
    localparam int PADDR_W     = 3;
    localparam int DATA_W      = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_BASE_OCTAVE = 1'b0;
    localparam logic REG_UNIT_LENGTH = 1'b1;

    localparam logic [OCTAVE_W-1:0] BASE_OCTAVE_RST = OCTAVE_W'(4);
    localparam logic [UNIT_W-1:0]   UNIT_LENGTH_RST = UNIT_W'(250);

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    // Exponent offset: octave 4 is the table octave, table is Q16.
    localparam logic [EXP_W-1:0] EXP_BIAS = EXP_W'(FREQ_FRAC_BITS - 16 - 4);

    // Event kinds.
    localparam logic [KIND_W-1:0] EV_TONE = 2'd0;
    localparam logic [KIND_W-1:0] EV_REST = 2'd1;
    localparam logic [KIND_W-1:0] EV_END  = 2'd2;

    // Octave marks and accidentals.
    localparam logic [1:0] OCT_NONE  = 2'd0;
    localparam logic [1:0] OCT_UP    = 2'd1;
    localparam logic [1:0] OCT_DOWN  = 2'd2;
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_SHARP = 2'd1;
    localparam logic [1:0] ACC_FLAT  = 2'd2;

    // ASCII characters of the notation.
    localparam logic [SYM_W-1:0] CH_COMMA = 8'h2C;  // ,
    localparam logic [SYM_W-1:0] CH_QUOTE = 8'h27;  // '
    localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;  // ^
    localparam logic [SYM_W-1:0] CH_UNDER = 8'h5F;  // _
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;  // /
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;  // 0
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;  // 9
    localparam logic [SYM_W-1:0] CH_UP_A  = 8'h41;  // A
    localparam logic [SYM_W-1:0] CH_UP_G  = 8'h47;  // G
    localparam logic [SYM_W-1:0] CH_LO_A  = 8'h61;  // a
    localparam logic [SYM_W-1:0] CH_LO_G  = 8'h67;  // g
    localparam logic [SYM_W-1:0] CH_REST_Z = 8'h7A; // z
    localparam logic [SYM_W-1:0] CH_REST_X = 8'h78; // x

    localparam logic [LEN_W-1:0] DEN_HALF    = LEN_W'(2);
    localparam logic [LEN_W-1:0] DEN_QUARTER = LEN_W'(4);

    // 2^(1/12) in Q30.
    localparam logic [63:0] HALF_Q30 = 64'd1137589835;

    function automatic logic [63:0] sharp_q16(input logic [63:0] q);
        return (q * HALF_Q30 + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] flat_q16(input logic [63:0] q);
        return ((q << 30) + HALF_Q30 / 2) / HALF_Q30;
    endfunction

    // Octave-4 natural pitches of A..G in Q16.
    localparam logic [63:0] PITCH_Q16 [7] = '{
        64'd28835840, 64'd32367136, 64'd17145893, 64'd19245614,
        64'd21602472, 64'd22887021, 64'd25689813
    };

    localparam logic [63:0] PITCH_SHARP [7] = '{
        sharp_q16(64'd28835840), sharp_q16(64'd32367136), sharp_q16(64'd17145893),
        sharp_q16(64'd19245614), sharp_q16(64'd21602472), sharp_q16(64'd22887021),
        sharp_q16(64'd25689813)
    };

    localparam logic [63:0] PITCH_FLAT [7] = '{
        flat_q16(64'd28835840), flat_q16(64'd32367136), flat_q16(64'd17145893),
        flat_q16(64'd19245614), flat_q16(64'd21602472), flat_q16(64'd22887021),
        flat_q16(64'd25689813)
    };

    function automatic logic [PITCH_W-1:0] pitch_lookup(
        input logic [LETTER_W-1:0] letter,
        input logic [1:0]          acc
    );
        logic [LETTER_W-1:0] idx;
        logic [63:0]         v;
        // Letter index seven wraps to A.
        idx = (letter == LETTER_W'(7)) ? '0 : letter;
        case (acc)
            ACC_SHARP: v = PITCH_SHARP[idx];
            ACC_FLAT:  v = PITCH_FLAT[idx];
            default:   v = PITCH_Q16[idx];
        endcase
        return v[PITCH_W-1:0];
    endfunction

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_LETTER = 6'b000010,
        PH_OCT    = 6'b000100,
        PH_ACC    = 6'b001000,
        PH_NUM    = 6'b010000,
        PH_SLASH  = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic                rest;
        logic [LETTER_W-1:0] letter;
        logic                lower;
        logic [1:0]          oct;
        logic [1:0]          acc;
        logic [LEN_W-1:0]    num;
        logic [LEN_W-1:0]    den;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase:  PH_IDLE,
        rest:   1'b0,
        letter: '0,
        lower:  1'b0,
        oct:    OCT_NONE,
        acc:    ACC_NONE,
        num:    LEN_W'(1),
        den:    LEN_W'(1)
    };

    typedef struct packed {
        logic take;
        logic decode;
        logic div_step;
        logic load_note;
        logic load_end;
    } mnp_cmd_t;

    typedef struct packed {
        logic dec_pend;
        logic dec_end;
        logic end_pend;
        logic div_done;
        logic out_full;
    } mnp_status_t;

endpackage

// ----- src/mnp_datapath.sv -----
// Parser state, character decode, pitch scaling, duration divider and
// the result register. Depends on mnp_pkg; driven by mnp_ctrl.
module mnp_datapath
    import mnp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [SYM_W-1:0]     s_symbol,
    input  logic                 s_new_song,
    input  logic [OCTAVE_W-1:0]  base_octave,
    input  logic [UNIT_W-1:0]    unit_length_ms,
    input  mnp_cmd_t             cmd,
    output mnp_status_t          status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_event_kind,
    output logic [FREQ_W-1:0]    m_frequency,
    output logic [DUR_W-1:0]     m_duration_ms,
    output logic                 m_last_of_run
);

    // Parser state.
    parse_state_t          ps_reg, ps_next;
    logic                  song_ended_reg, song_ended_next;
    logic [SYM_W-1:0]      sym_reg;

    // Snapshot of the note being emitted.
    logic [PITCH_W-1:0]    wq_reg;
    logic [EXP_W-1:0]      we_reg;
    logic                  wrest_reg;
    logic                  wden_zero_reg;
    logic [LEN_W-1:0]      wden_reg;
    logic                  end_pend_reg;
    logic [DUR_W-1:0]      quot_reg, quot_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [FREQ_W-1:0]     freq_reg, freq_next;

    // Result register.
    logic                  out_valid_reg;
    logic [KIND_W-1:0]     out_kind_reg;
    logic [FREQ_W-1:0]     out_freq_reg;
    logic [DUR_W-1:0]      out_dur_reg;
    logic                  out_last_reg;

    // Decode signals.
    logic                  is_digit;
    logic [LEN_W-1:0]      digit_val;
    logic                  used;
    logic                  dec_pend;
    logic                  dec_end;
    logic [LEN_W-1:0]      den_eff;
    logic [EXP_W-1:0]      oct_adj;
    logic [EXP_W-1:0]      exp_calc;
    logic [DUR_W-1:0]      prod;

    // Scaling and division signals.
    logic [LSH_W-1:0]      lsh;
    logic [RND_W-1:0]      rnd;
    logic [EXP_W-1:0]      r_mag;
    logic [RSH_AMT_W-1:0]  rsh;
    logic [REM_W:0]        rem_sh;

    assign is_digit  = (sym_reg >= CH_ZERO) && (sym_reg <= CH_NINE);
    assign digit_val = sym_reg[LEN_W-1:0];

    always_comb begin
        ps_next         = ps_reg;
        song_ended_next = song_ended_reg;
        used            = 1'b0;
        dec_pend        = 1'b0;
        dec_end         = 1'b0;
        den_eff         = ps_reg.den;
        if (!song_ended_reg) begin
            if (ps_reg.phase != PH_IDLE) begin
                if (ps_reg.phase == PH_LETTER &&
                    (sym_reg == CH_COMMA || sym_reg == CH_QUOTE)) begin
                    ps_next.oct   = (sym_reg == CH_QUOTE) ? OCT_UP : OCT_DOWN;
                    ps_next.phase = PH_OCT;
                    used          = 1'b1;
                end else if ((ps_reg.phase == PH_LETTER || ps_reg.phase == PH_OCT) &&
                             (sym_reg == CH_CARET || sym_reg == CH_UNDER)) begin
                    ps_next.acc   = (sym_reg == CH_CARET) ? ACC_SHARP : ACC_FLAT;
                    ps_next.phase = PH_ACC;
                    used          = 1'b1;
                end else if ((ps_reg.phase == PH_LETTER || ps_reg.phase == PH_OCT ||
                              ps_reg.phase == PH_ACC) && is_digit) begin
                    ps_next.num   = digit_val;
                    ps_next.phase = PH_NUM;
                    used          = 1'b1;
                end else if ((ps_reg.phase == PH_LETTER || ps_reg.phase == PH_OCT ||
                              ps_reg.phase == PH_ACC || ps_reg.phase == PH_NUM) &&
                             sym_reg == CH_SLASH) begin
                    ps_next.den   = DEN_HALF;
                    ps_next.phase = PH_SLASH;
                    used          = 1'b1;
                end else if (ps_reg.phase == PH_SLASH &&
                             (sym_reg == CH_SLASH || is_digit)) begin
                    // The denominator completes the note, so it goes out now.
                    den_eff  = (sym_reg == CH_SLASH) ? DEN_QUARTER : digit_val;
                    dec_pend = 1'b1;
                    ps_next  = PARSE_CLEAR;
                    used     = 1'b1;
                end
                if (!used) begin
                    dec_pend = 1'b1;
                    ps_next  = PARSE_CLEAR;
                end
            end
            if (!used) begin
                if (sym_reg >= CH_UP_A && sym_reg <= CH_UP_G) begin
                    ps_next.letter = LETTER_W'(sym_reg - CH_UP_A);
                    ps_next.lower  = 1'b0;
                    ps_next.phase  = PH_LETTER;
                end else if (sym_reg >= CH_LO_A && sym_reg <= CH_LO_G) begin
                    ps_next.letter = LETTER_W'(sym_reg - CH_LO_A);
                    ps_next.lower  = 1'b1;
                    ps_next.phase  = PH_LETTER;
                end else if (sym_reg == CH_REST_Z || sym_reg == CH_REST_X) begin
                    ps_next.rest   = 1'b1;
                    ps_next.phase  = PH_ACC;
                end else begin
                    dec_end         = 1'b1;
                    song_ended_next = 1'b1;
                    ps_next         = PARSE_CLEAR;
                end
            end
        end
    end

    always_comb begin
        case (ps_reg.oct)
            OCT_UP:   oct_adj = EXP_W'(1);
            OCT_DOWN: oct_adj = '1;
            default:  oct_adj = '0;
        endcase
        exp_calc = EXP_W'(base_octave) + EXP_W'(ps_reg.lower) + oct_adj + EXP_BIAS;
        prod     = DUR_W'(unit_length_ms) * DUR_W'(ps_reg.num);
    end

    // Scale the Q16 pitch by 2^exponent; a right shift rounds half up.
    always_comb begin
        lsh   = LSH_W'(wq_reg) << we_reg[LSH_AMT_W-1:0];
        r_mag = -we_reg;
        rsh   = r_mag[RSH_AMT_W-1:0];
        rnd   = (RND_W'(wq_reg) + (RND_W'(1) << (rsh - 1'b1))) >> rsh;
        if (!we_reg[EXP_W-1]) begin
            if (we_reg > EXP_W'(LSH_MAX)) begin
                freq_next = (wq_reg != '0) ? FREQ_MAX : '0;
            end else if (lsh[LSH_W-1:FREQ_W] != '0) begin
                freq_next = FREQ_MAX;
            end else begin
                freq_next = lsh[FREQ_W-1:0];
            end
        end else begin
            if (r_mag > EXP_W'(RSH_MAX)) begin
                freq_next = '0;
            end else if (rnd[RND_W-1:FREQ_W] != '0) begin
                freq_next = FREQ_MAX;
            end else begin
                freq_next = rnd[FREQ_W-1:0];
            end
        end
    end

    // Restoring division, one quotient bit per step.
    always_comb begin
        rem_sh = {rem_reg, quot_reg[DUR_W-1]};
        if (rem_sh >= {1'b0, wden_reg}) begin
            rem_next  = REM_W'(rem_sh - {1'b0, wden_reg});
            quot_next = {quot_reg[DUR_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh[REM_W-1:0];
            quot_next = {quot_reg[DUR_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg         <= PARSE_CLEAR;
            song_ended_reg <= 1'b0;
            end_pend_reg   <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.take) begin
                sym_reg <= s_symbol;
                if (s_new_song) begin
                    ps_reg         <= PARSE_CLEAR;
                    song_ended_reg <= 1'b0;
                end
            end
            if (cmd.decode) begin
                ps_reg         <= ps_next;
                song_ended_reg <= song_ended_next;
                end_pend_reg   <= dec_end;
                wq_reg         <= pitch_lookup(ps_reg.letter, ps_reg.acc);
                we_reg         <= exp_calc;
                wrest_reg      <= ps_reg.rest;
                wden_reg       <= den_eff;
                wden_zero_reg  <= (den_eff == '0);
                quot_reg       <= prod;
                rem_reg        <= '0;
                cnt_reg        <= '0;
            end
            if (cmd.div_step) begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg + 1'b1;
                freq_reg <= freq_next;
            end
            if (cmd.load_note) begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= wrest_reg ? EV_REST : EV_TONE;
                out_freq_reg  <= wrest_reg ? '0 : freq_reg;
                out_dur_reg   <= wden_zero_reg ? '0 : quot_reg;
                out_last_reg  <= !end_pend_reg;
            end else if (cmd.load_end) begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= EV_END;
                out_freq_reg  <= '0;
                out_dur_reg   <= '0;
                out_last_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.dec_pend = dec_pend;
    assign status.dec_end  = dec_end;
    assign status.end_pend = end_pend_reg;
    assign status.div_done = (cnt_reg == CNT_W'(DIV_STEPS));
    assign status.out_full = out_valid_reg;

    assign m_valid       = out_valid_reg;
    assign m_event_kind  = out_kind_reg;
    assign m_frequency   = out_freq_reg;
    assign m_duration_ms = out_dur_reg;
    assign m_last_of_run = out_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_note || cmd.load_end) |-> !out_valid_reg)
        else $error("result register loaded while still full");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DIV_STEPS))
        else $error("division step count overran");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_end |=> (m_last_of_run && m_event_kind == EV_END))
        else $error("end event is not the last item of its run");

endmodule

// ----- src/mnp_ctrl.sv -----
// Sequencer of the note parser: takes an item, decodes it, runs the
// divider and loads up to two results. Depends on mnp_pkg.
module mnp_ctrl
    import mnp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mnp_status_t status,
    output mnp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_NOTE   = 5'b01000,
        ST_END    = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                if (status.dec_pend) begin
                    state_next = ST_DIV;
                end else if (status.dec_end) begin
                    state_next = ST_END;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_NOTE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_NOTE: begin
                if (!status.out_full) begin
                    cmd.load_note = 1'b1;
                    state_next    = status.end_pend ? ST_END : ST_IDLE;
                end
            end
            ST_END: begin
                if (!status.out_full) begin
                    cmd.load_end = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_take_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted item was not decoded next");

    a_end_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_note && status.end_pend) |=> (state_reg == ST_END))
        else $error("end event after a note was dropped");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

endmodule

// ----- src/music_notation_note_parser.sv -----
// Top level of the note parser: APB register file, sequencer and datapath.
// Depends on mnp_pkg, mnp_ctrl and mnp_datapath.
//
//   Port group   Direction  Handshake        Content
//   s_*          in         s_valid/s_ready  one song character per item
//   m_*          out        m_valid/m_ready  one note, rest or end event per item
//   APB          in/out     psel/penable     base_octave at 0x0, unit_length_ms at 0x4
//
// An item that emits nothing is taken and decoded; one that emits only an end
// event then also loads it; one that emits a note runs the bit-serial duration
// divider before the note is loaded, and then the end event if one follows.
// The result register holds a finished result while the next item is taken.
// Reset is synchronous and active low; it clears the parser and song end flag.
// A stalled result delays the next result load, and no item is taken meanwhile.
module music_notation_note_parser
    import mnp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SYM_W-1:0]    s_symbol,
    input  logic                s_new_song,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [KIND_W-1:0]   m_event_kind,
    output logic [FREQ_W-1:0]   m_frequency,
    output logic [DUR_W-1:0]    m_duration_ms,
    output logic                m_last_of_run,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [OCTAVE_W-1:0] base_octave_reg;
    logic [UNIT_W-1:0]   unit_length_reg;
    logic                cfg_wr;
    mnp_cmd_t            cmd;
    mnp_status_t         status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_octave_reg <= BASE_OCTAVE_RST;
            unit_length_reg <= UNIT_LENGTH_RST;
        end else if (cfg_wr) begin
            case (paddr[REG_SEL_BIT])
                REG_BASE_OCTAVE: base_octave_reg <= pwdata[OCTAVE_W-1:0];
                REG_UNIT_LENGTH: unit_length_reg <= pwdata[UNIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_BASE_OCTAVE: prdata = DATA_W'(base_octave_reg);
            REG_UNIT_LENGTH: prdata = DATA_W'(unit_length_reg);
            default:         prdata = '0;
        endcase
    end

    mnp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mnp_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_symbol       (s_symbol),
        .s_new_song     (s_new_song),
        .base_octave    (base_octave_reg),
        .unit_length_ms (unit_length_reg),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_frequency    (m_frequency),
        .m_duration_ms  (m_duration_ms),
        .m_last_of_run  (m_last_of_run)
    );

endmodule
